@@ hdl/pd_controller_saturating_top_macros.svh @@
// assertion macros for the pd controller top level
// no dependencies; included by pd_controller_saturating_top.sv
`ifndef PD_CONTROLLER_SATURATING_TOP_MACROS_SVH
`define PD_CONTROLLER_SATURATING_TOP_MACROS_SVH

// condition holds in the same cycle
`define PDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdc assertion failed");

// condition holds in the following cycle
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdc assertion failed");

`endif

@@ hdl/pdc_pkg.sv @@
// shared types and constants for the pd controller
// no dependencies; used by pdc_scale and pd_controller_saturating_top
package pdc_pkg;

   localparam int unsigned DataWidth  = 16;
   localparam int unsigned DriveWidth = 8;
   localparam int unsigned ProdWidth  = 2 * DataWidth + 1;
   localparam int unsigned SumWidth   = ProdWidth + 1;
   localparam int unsigned CsrIdxWidth = 2;

   localparam int signed SatLimit = 32767;
   localparam int signed DriveMax = 127;

   typedef logic signed [DataWidth-1:0]  sample_type;
   typedef logic        [DataWidth-1:0]  gain_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [SumWidth-1:0]   sum_type;
   typedef logic signed [DriveWidth-1:0] drive_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TARGET_VALUE = 2'd0,
      CSR_PROP_GAIN    = 2'd1,
      CSR_DERIV_GAIN   = 2'd2
   } csr_index_type;

endpackage

@@ hdl/pdc_scale.sv @@
// scales a clamped sum by 127/32767, truncating toward zero
// depends on pdc_pkg
module pdc_scale
   import pdc_pkg::*;
(
   input  sample_type clamped,
   output drive_type  drive
);

   logic        neg;
   logic [14:0] mag;
   logic [21:0] prod;
   logic [6:0]  quo_lo;
   logic [15:0] rem;
   logic [7:0]  quo;

   // divide by 2^15-1: high part plus one correction
   always_comb begin
      neg    = clamped[15];
      mag    = neg ? 15'(-clamped) : clamped[14:0];
      prod   = ({mag, 7'd0}) - 22'(mag);
      quo_lo = prod[21:15];
      rem    = {1'b0, prod[14:0]} + 16'(quo_lo);
      quo    = {1'b0, quo_lo} + ((rem >= 16'(SatLimit)) ? 8'd1 : 8'd0);
      drive  = neg ? drive_type'(-quo) : drive_type'(quo);
   end

endmodule

@@ hdl/pd_controller_saturating_top.sv @@
// pd controller with saturated, scaled 8-bit drive output
// depends on pdc_pkg, pdc_scale and pd_controller_saturating_top_macros.svh
//
// req_ channel carries one measured value per word; rsp_ channel returns
// exactly one drive value per accepted word, in order. csr_ writes set the
// setpoint and the two gains; write them only while the block is idle.
// four register stages: error and derivative, the two gain products, the
// clamped sum, and the scaled drive value in the output register. one word
// per cycle is sustained while rsp_tready stays high; the previous error is
// updated as each word is accepted, so back to back words see it at once.
// each stage holds its word only while the stage after it is full, so a
// stalled receiver fills the pipeline before req_tready falls.
// synchronous reset clears the valid flags of all stages, the previous
// error and the configuration registers.
`include "pd_controller_saturating_top_macros.svh"

module pd_controller_saturating_top
   import pdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [15:0] measured_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] drive_value
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   sample_type target_ff, target_in;
   gain_type   prop_gain_ff, prop_gain_in;
   gain_type   deriv_gain_ff, deriv_gain_in;
   sample_type last_error_ff, last_error_in;

   logic       s1_valid_ff, s1_valid_in;
   sample_type err_ff, err_in;
   sample_type der_ff, der_in;

   logic       s2_valid_ff, s2_valid_in;
   prod_type   prod_p_ff, prod_p_in;
   prod_type   prod_d_ff, prod_d_in;

   logic       s3_valid_ff, s3_valid_in;
   sample_type clamp_ff, clamp_in;

   logic       out_valid_ff, out_valid_in;
   drive_type  drive_ff, drive_in;

   logic       rdy_out, rdy3, rdy2, rdy1, req_accept;
   sum_type    sum;
   drive_type  scaled;

   assign rdy_out    = !out_valid_ff || rsp_tready;
   assign rdy3       = !s3_valid_ff || rdy_out;
   assign rdy2       = !s2_valid_ff || rdy3;
   assign rdy1       = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;
   assign req_accept = req_tvalid && rdy1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;

   // configuration registers
   always_comb begin
      target_in     = target_ff;
      prop_gain_in  = prop_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_VALUE: target_in     = sample_type'(csr_wdata);
            CSR_PROP_GAIN:    prop_gain_in  = csr_wdata;
            CSR_DERIV_GAIN:   deriv_gain_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: error and derivative
   always_comb begin
      s1_valid_in   = rdy1 ? req_tvalid : s1_valid_ff;
      err_in        = err_ff;
      der_in        = der_ff;
      last_error_in = last_error_ff;
      if (req_accept) begin
         err_in        = target_ff - sample_type'(req_tdata);
         der_in        = err_in - last_error_ff;
         last_error_in = err_in;
      end
   end

   // stage 2: gain products
   always_comb begin
      s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
      prod_p_in   = prod_p_ff;
      prod_d_in   = prod_d_ff;
      if (rdy2 && s1_valid_ff) begin
         prod_p_in = prod_type'({1'b0, prop_gain_ff}) * prod_type'(err_ff);
         prod_d_in = prod_type'({1'b0, deriv_gain_ff}) * prod_type'(der_ff);
      end
   end

   // stage 3: sum and clamp
   always_comb begin
      sum         = sum_type'(prod_p_ff) + sum_type'(prod_d_ff);
      s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;
      clamp_in    = clamp_ff;
      if (rdy3 && s2_valid_ff) begin
         if (sum > sum_type'(SatLimit)) begin
            clamp_in = sample_type'(SatLimit);
         end else if (sum < sum_type'(-SatLimit)) begin
            clamp_in = sample_type'(-SatLimit);
         end else begin
            clamp_in = sum[DataWidth-1:0];
         end
      end
   end

   pdc_scale u_scale (
      .clamped (clamp_ff),
      .drive   (scaled)
   );

   // stage 4: output register
   always_comb begin
      out_valid_in = rdy_out ? s3_valid_ff : out_valid_ff;
      drive_in     = (rdy_out && s3_valid_ff) ? scaled : drive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         prop_gain_ff  <= '0;
         deriv_gain_ff <= '0;
         last_error_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         target_ff     <= target_in;
         prop_gain_ff  <= prop_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         last_error_ff <= last_error_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      der_ff    <= der_in;
      prod_p_ff <= prod_p_in;
      prod_d_ff <= prod_d_in;
      clamp_ff  <= clamp_in;
      drive_ff  <= drive_in;
   end

   `PDC_ASSERT_NOW(a_drive_range, clock, reset, rsp_tvalid, rsp_tdata != 8'h80)
   `PDC_ASSERT_NOW(a_clamp_range, clock, reset, s3_valid_ff, clamp_ff != 16'sh8000)
   `PDC_ASSERT_NEXT(a_last_error, clock, reset, req_accept, last_error_ff == err_ff)
   `PDC_ASSERT_NOW(a_ready_empty, clock, reset, !s1_valid_ff, req_tready)

endmodule
